// File: hdl/assert_macros.svh
// Assertion helpers for the RTL, included by iq_fir_filter_core.
// All checks are sampled on the rising edge of clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition or implication that must hold at every edge.
`define IQFIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger at one edge requires a condition at the next edge.
`define IQFIR_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// File: hdl/iqfir_pkg.sv
// ----------------------------------------------------------------------------
// iqfir_pkg
// Types, constants and rounding helper shared by the I/Q FIR filter modules.
// ----------------------------------------------------------------------------
package iqfir_pkg;

  localparam int DEF_MAX_TAPS = 256;
  localparam int COEF_W       = 16;
  localparam int SAMP_W       = 16;
  localparam int PROD_W       = COEF_W + SAMP_W;
  localparam int ACC_W        = 40;
  localparam int FRAC_W       = 15;
  localparam int TAPCNT_W     = 9;
  localparam int CIDX_W       = 8;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TAPCNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_EN   = 1'd1;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 9'd256;

  localparam logic signed [SAMP_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMP_W-1:0] SAT_MIN = -16'sh8000;

  typedef struct packed {
    logic                     func;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SAMP_W-1:0] sample_i;
    logic signed [SAMP_W-1:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] result_i;
    logic signed [SAMP_W-1:0] result_q;
  } out_item_t;

  // Per-tap control that travels alongside the memory read data
  typedef struct packed {
    logic vld;
    logic live;   // delay line entry has been written
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic done;     // last tap summed this cycle
    logic res_vld;  // rounded result waiting to be taken
  } mac_sts_t;

  // Round half up to Q1.15, then saturate to 16 bits.
  function automatic logic signed [SAMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]        v;
    logic signed [ACC_W-FRAC_W:0] q;
    logic signed [SAMP_W-1:0]     r;
    v = ACC_W'(a) + (ACC_W+1)'(1 << (FRAC_W - 1));
    q = $signed(v[ACC_W:FRAC_W]);
    if (q > SAT_MAX) begin
      r = SAT_MAX;
    end else if (q < SAT_MIN) begin
      r = SAT_MIN;
    end else begin
      r = q[SAMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/iqfir_ram.sv
// ----------------------------------------------------------------------------
// iqfir_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module iqfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/iqfir_mac.sv
// ----------------------------------------------------------------------------
// iqfir_mac
// Dual multiply-accumulate datapath: product stage, 40-bit accumulators,
// round/saturate stage holding the result until it is taken.
// ----------------------------------------------------------------------------
module iqfir_mac import iqfir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_ctl_t              ctl,
  input  logic [COEF_W-1:0]     coef,
  input  logic [2*SAMP_W-1:0]   samp,
  input  logic                  quad_en,
  input  logic                  res_take,
  output mac_sts_t              sts,
  output out_item_t             res
);

  logic signed [COEF_W-1:0] coef_s;
  logic signed [SAMP_W-1:0] samp_i;
  logic signed [SAMP_W-1:0] samp_q;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;

  mac_ctl_t                 a_ctl_r;
  logic signed [PROD_W-1:0] pa_i_r;
  logic signed [PROD_W-1:0] pa_q_r;
  logic signed [ACC_W-1:0]  acc_i_r;
  logic signed [ACC_W-1:0]  acc_q_r;
  logic signed [ACC_W-1:0]  acc_i_nxt;
  logic signed [ACC_W-1:0]  acc_q_nxt;
  logic                     b_last_r;
  logic                     res_vld_r;
  out_item_t                res_r;

  assign coef_s = $signed(coef);
  assign samp_i = $signed(samp[SAMP_W-1:0]);
  assign samp_q = $signed(samp[2*SAMP_W-1:SAMP_W]);
  assign prod_i = coef_s * samp_i;
  assign prod_q = coef_s * samp_q;

  // Product stage; unwritten delay entries count as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else begin
      a_ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    pa_i_r <= ctl.live ? prod_i : '0;
    pa_q_r <= ctl.live ? prod_q : '0;
  end

  // Accumulate stage, wraps modulo 2^40
  assign acc_i_nxt = a_ctl_r.first ? ACC_W'(pa_i_r) : acc_i_r + ACC_W'(pa_i_r);
  assign acc_q_nxt = a_ctl_r.first ? ACC_W'(pa_q_r) : acc_q_r + ACC_W'(pa_q_r);

  always_ff @(posedge clk) begin
    if (a_ctl_r.vld) begin
      acc_i_r <= acc_i_nxt;
      acc_q_r <= acc_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_last_r <= 1'b0;
    end else begin
      b_last_r <= a_ctl_r.vld && a_ctl_r.last;
    end
  end

  // Round/saturate stage
  always_ff @(posedge clk) begin
    if (b_last_r) begin
      res_r.result_i <= round_sat(acc_i_r);
      res_r.result_q <= quad_en ? round_sat(acc_q_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (b_last_r) begin
      res_vld_r <= 1'b1;
    end else if (res_take) begin
      res_vld_r <= 1'b0;
    end
  end

  assign sts.done    = b_last_r;
  assign sts.res_vld = res_vld_r;
  assign res         = res_r;

endmodule

// File: hdl/iq_fir_filter_core.sv
// Sample item: T taps (T = taps in use, 1..MAX_TAPS) pass memory read, product, accumulate and
// round/saturate. Items are taken only while idle and no result is pending; loads one per cycle.
// Sample rate is set by the single MAC stream: one tap read from each memory per cycle.
// Reset (synchronous, rst_n low): delay lines read as zero via a fill count, no clearing pass;
// write position 0, tap_count 256, quadrature on; coefficients undefined until loaded.
// ----------------------------------------------------------------------------
// iq_fir_filter_core
// Direct-form I/Q FIR filter: coefficient RAM, I/Q delay-line RAM, tap
// sequencer, MAC datapath and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iq_fir_filter_core import iqfir_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int CW  = AW + 1;
  localparam int TCW = (CW > TAPCNT_W) ? CW : TAPCNT_W;
  localparam int IXW = (CW > CIDX_W) ? CW : CIDX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [TAPCNT_W-1:0] tap_count_r;
  logic                quad_en_r;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       taps_r, taps_nxt;
  logic [CW-1:0]       tap_k_r, tap_k_nxt;
  logic [AW-1:0]       rd_pos_r, rd_pos_nxt;

  logic                in_acc;
  logic                load_acc;
  logic                samp_acc;
  logic                coef_ok;
  logic [TCW-1:0]      tc_ext;
  logic [CW-1:0]       taps_use;
  logic [AW-1:0]       wp_dec;
  logic                iss_last;

  mac_ctl_t            iss_ctl;
  mac_ctl_t            s1_ctl_r;
  mac_sts_t            mac_sts;
  out_item_t           mac_res;
  logic                out_load;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [COEF_W-1:0]   coef_rd;
  logic [2*SAMP_W-1:0] samp_rd;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
      quad_en_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_COUNT: tap_count_r <= cfg_wdata;
        CFG_QUAD_EN:   quad_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Tap count 0 acts as 1, above MAX_TAPS acts as MAX_TAPS
  assign tc_ext   = TCW'(tap_count_r);
  assign taps_use = (tap_count_r == '0) ? CW'(1) :
                    (tc_ext > TCW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tc_ext);

  // ---------------- input handshake ----------------
  assign in_ready = (state_r == ST_IDLE) && !mac_sts.res_vld;
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && (in_item.func == FUNC_LOAD);
  assign samp_acc = in_acc && (in_item.func == FUNC_SAMPLE);
  assign coef_ok  = IXW'(in_item.coef_index) < IXW'(MAX_TAPS);

  assign wp_dec   = (wp_r == '0) ? AW'(MAX_TAPS - 1) : wp_r - AW'(1);
  assign iss_last = (tap_k_r == taps_r - CW'(1));

  // ---------------- tap sequencer ----------------
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    taps_nxt   = taps_r;
    tap_k_nxt  = tap_k_r;
    rd_pos_nxt = rd_pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (samp_acc) begin
          wp_nxt     = wp_dec;
          fill_nxt   = (fill_r == CW'(MAX_TAPS)) ? fill_r : fill_r + CW'(1);
          taps_nxt   = taps_use;
          tap_k_nxt  = '0;
          rd_pos_nxt = wp_dec;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        tap_k_nxt  = tap_k_r + CW'(1);
        rd_pos_nxt = (rd_pos_r == AW'(MAX_TAPS - 1)) ? '0 : rd_pos_r + AW'(1);
        if (iss_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taps_r   <= taps_nxt;
    tap_k_r  <= tap_k_nxt;
    rd_pos_r <= rd_pos_nxt;
  end

  // Control aligned with the registered memory read data
  assign iss_ctl.vld   = (state_r == ST_RUN);
  assign iss_ctl.live  = tap_k_r < fill_r;
  assign iss_ctl.first = (tap_k_r == '0);
  assign iss_ctl.last  = iss_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= iss_ctl;
    end
  end

  // ---------------- memories ----------------
  iqfir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_acc && coef_ok),
    .waddr (AW'(in_item.coef_index)),
    .wdata (in_item.coef_value),
    .raddr (tap_k_r[AW-1:0]),
    .rdata (coef_rd)
  );

  iqfir_ram #(
    .WIDTH (2 * SAMP_W),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (samp_acc),
    .waddr (wp_dec),
    .wdata ({in_item.sample_q, in_item.sample_i}),
    .raddr (rd_pos_r),
    .rdata (samp_rd)
  );

  // ---------------- MAC datapath ----------------
  iqfir_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (s1_ctl_r),
    .coef     (coef_rd),
    .samp     (samp_rd),
    .quad_en  (quad_en_r),
    .res_take (out_load),
    .sts      (mac_sts),
    .res      (mac_res)
  );

  // ---------------- output register ----------------
  assign out_load = mac_sts.res_vld && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= mac_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------- assertions ----------------
  `IQFIR_ASSERT_NEXT(a_sample_starts_run, samp_acc, state_r == ST_RUN, "sample item did not start tap run")
  `IQFIR_ASSERT(a_done_in_drain, mac_sts.done |-> (state_r == ST_DRAIN), "MAC finished outside drain")
  `IQFIR_ASSERT(a_tap_in_range, (state_r == ST_RUN) |-> (tap_k_r < taps_r), "tap index past tap count")
  `IQFIR_ASSERT(a_no_result_overrun, mac_sts.done |-> !mac_sts.res_vld, "MAC result overwritten before taken")

endmodule
